// ===== rtl/bfdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdf_pkg: shared types and constants for the broadcast frame dedupe filter
// Item and result layouts, verdict and register codes, cache sizing.
// ----------------------------------------------------------------------------
package bfdf_pkg;

	localparam int CACHE_DEPTH = 16;
	localparam int SLOT_W      = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_DEPTH - 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0] RST_FRAME_MAGIC     = 8'd0;
	localparam logic [7:0] RST_FRAME_VERSION   = 8'd1;
	localparam logic [7:0] RST_AUDIO_RAW_TYPE  = 8'd0;
	localparam logic [7:0] RST_AUDIO_OPUS_TYPE = 8'd1;
	localparam logic [7:0] RST_HEADER_BYTES    = 8'd16;
	localparam logic       RST_DELIVER_ENABLE  = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_MAGIC     = 3'd0,
		REG_FRAME_VERSION   = 3'd1,
		REG_AUDIO_RAW_TYPE  = 3'd2,
		REG_AUDIO_OPUS_TYPE = 3'd3,
		REG_HEADER_BYTES    = 3'd4,
		REG_DELIVER_ENABLE  = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		VERDICT_SHORT    = 3'd0,
		VERDICT_BADHDR   = 3'd1,
		VERDICT_NOTAUDIO = 3'd2,
		VERDICT_DUP      = 3'd3,
		VERDICT_EXPIRED  = 3'd4,
		VERDICT_FORWARD  = 3'd5
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic [10:0] frame_length;
		logic [7:0]  magic;
		logic [7:0]  version;
		logic [7:0]  frame_type;
		logic [7:0]  src_stream;
		logic [15:0] seq;
		logic [7:0]  ttl;
	} frame_in_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic [7:0] new_ttl;
		logic       deliver;
	} result_t;

	typedef struct packed {
		logic [7:0]  src_stream;
		logic [15:0] seq;
	} cache_entry_t;

endpackage

// ===== rtl/broadcast_frame_dedupe_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_frame_dedupe_filter
// Header checks and duplicate suppression over a round-robin cache of recent
// (stream, sequence) pairs, one cache entry compared per cycle.
// ----------------------------------------------------------------------------
//  channel   signals                           handshake
//  --------  --------------------------------  ------------------------------
//  item in   start, frame, busy                taken when start && !busy
//  result    done, result                      one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data       written when cfg_we is high
//
//  An audio item that passes the header checks reads every cache entry in
//  turn, one cache read per cycle through the single comparator, then passes
//  a drain state and a decide state. Any other item goes straight to the
//  decide state. busy is low in the cycle that done is high. Reset returns
//  the configuration and control registers to their defaults and marks every
//  cache entry as zero; no clearing pass is needed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module broadcast_frame_dedupe_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  bfdf_pkg::frame_in_t                 frame,
	output logic                                busy,
	output logic                                done,
	output bfdf_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [bfdf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bfdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bfdf_pkg::*;

	// configuration
	logic [7:0] frame_magic_q;
	logic [7:0] frame_version_q;
	logic [7:0] audio_raw_type_q;
	logic [7:0] audio_opus_type_q;
	logic [7:0] header_bytes_q;
	logic       deliver_enable_q;

	// sequencer
	state_t      state_q, state_nxt;
	logic        accept;
	logic        rd_en;
	logic        decide;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] slot_q;

	// item held for the scan
	cache_entry_t key_q;
	logic [7:0]   ttl_q;
	logic         pass_q;
	logic         len_gt_q;
	verdict_t     pre_verdict_q;
	logic         hit_q;

	// cache
	cache_entry_t cache_mem [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] valid_q;
	cache_entry_t rd_data_q;
	logic         rd_valid_q;
	logic         rd_vld_s1;
	cache_entry_t entry;
	logic         match;
	logic         cache_wr;

	// early checks
	logic     pre_pass;
	verdict_t pre_verdict;
	verdict_t verdict;
	logic     forward;

	always_comb begin
		pre_pass    = 1'b0;
		pre_verdict = VERDICT_NOTAUDIO;
		if (frame.frame_length < {3'b000, header_bytes_q}) begin
			pre_verdict = VERDICT_SHORT;
		end else if (frame.magic != frame_magic_q || frame.version != frame_version_q) begin
			pre_verdict = VERDICT_BADHDR;
		end else if (frame.frame_type != audio_raw_type_q &&
				frame.frame_type != audio_opus_type_q) begin
			pre_verdict = VERDICT_NOTAUDIO;
		end else begin
			pre_pass = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = pre_pass ? ST_SCAN : ST_DECIDE;
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST_SLOT) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_nxt = ST_DECIDE;
			ST_DECIDE: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy   = 1'b1;
		accept = 1'b0;
		rd_en  = 1'b0;
		decide = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				accept = start;
			end
			ST_SCAN:   rd_en  = 1'b1;
			ST_DRAIN:  rd_en  = 1'b0;
			ST_DECIDE: decide = 1'b1;
			default:   busy   = 1'b1;
		endcase
	end

	// shared comparator: an entry never written reads as zero
	always_comb begin
		entry = rd_valid_q ? rd_data_q : '0;
		match = rd_vld_s1 && (entry == key_q);
	end

	always_comb begin
		if (!pass_q) begin
			verdict = pre_verdict_q;
		end else if (hit_q) begin
			verdict = VERDICT_DUP;
		end else if (ttl_q == 8'd0) begin
			verdict = VERDICT_EXPIRED;
		end else begin
			verdict = VERDICT_FORWARD;
		end
		forward  = (verdict == VERDICT_FORWARD);
		cache_wr = decide && pass_q && !hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_magic_q     <= RST_FRAME_MAGIC;
			frame_version_q   <= RST_FRAME_VERSION;
			audio_raw_type_q  <= RST_AUDIO_RAW_TYPE;
			audio_opus_type_q <= RST_AUDIO_OPUS_TYPE;
			header_bytes_q    <= RST_HEADER_BYTES;
			deliver_enable_q  <= RST_DELIVER_ENABLE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_MAGIC:     frame_magic_q     <= cfg_data;
				REG_FRAME_VERSION:   frame_version_q   <= cfg_data;
				REG_AUDIO_RAW_TYPE:  audio_raw_type_q  <= cfg_data;
				REG_AUDIO_OPUS_TYPE: audio_opus_type_q <= cfg_data;
				REG_HEADER_BYTES:    header_bytes_q    <= cfg_data;
				REG_DELIVER_ENABLE:  deliver_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			slot_q    <= '0;
			hit_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			done      <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= rd_en;
			done      <= decide;
			if (accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (cache_wr) begin
				valid_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
		end
	end

	// hold the item for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.src_stream <= frame.src_stream;
			key_q.seq        <= frame.seq;
			ttl_q            <= frame.ttl;
			pass_q           <= pre_pass;
			pre_verdict_q    <= pre_verdict;
			len_gt_q         <= frame.frame_length > {3'b000, header_bytes_q};
		end
	end

	// cache memory, registered read
	always_ff @(posedge clk) begin
		if (cache_wr) begin
			cache_mem[slot_q] <= key_q;
		end
		if (rd_en) begin
			rd_data_q  <= cache_mem[idx_q];
			rd_valid_q <= valid_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			result.verdict <= verdict;
			result.new_ttl <= forward ? ttl_q - 8'd1 : ttl_q;
			result.deliver <= forward && deliver_enable_q && len_gt_q;
		end
	end

endmodule

// ===== rtl/bfdf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdf_checker: port-level checks for the broadcast frame dedupe filter
// Watches the item, result and busy signals over time.
// ----------------------------------------------------------------------------
module bfdf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input bfdf_pkg::result_t result
);
	import bfdf_pkg::*;

	// an accepted item keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result appears only once the block has dropped busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// one result per item; done is never high on consecutive cycles
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// deliver only on a forwarded frame
	a_deliver_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.deliver |-> result.verdict == VERDICT_FORWARD)
		else $error("deliver set on a frame that is not forwarded");

	// a forwarded frame never carries a wrapped ttl
	a_ttl_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.verdict == VERDICT_FORWARD |-> result.new_ttl != 8'hFF)
		else $error("forwarded frame with wrapped ttl");

endmodule

bind broadcast_frame_dedupe_filter bfdf_checker u_bfdf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
